// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that checks its own behaviour.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Whenever the trigger holds, the consequence holds at the same edge.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/crt_pkg.sv -----
`timescale 1ns / 1ps
package crt_pkg;

	localparam int MAX_CELLS_DEF = 1024;
	localparam int POS_W = 11;
	localparam int RUN_W = 11;
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] CELLS_RESET = 11'd1024;
	localparam int WORD_W = 32;
	localparam int BIT_W = 5;
	localparam int CNT_W = 6;

	localparam logic [1:0] CMD_QUERY = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_REBUILD = 2'd2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_QUERY,
		K_DESTROY,
		K_REBUILD,
		K_REPORT
	} kind_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CENTER,
		S_LEFT,
		S_RIGHT,
		S_DWR,
		S_RSTK,
		S_RWR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [POS_W-1:0] position;
	} cmd_t;

	typedef struct packed {
		logic [RUN_W-1:0] run_length;
		status_t status;
	} res_t;

	typedef struct packed {
		kind_t kind;
		logic [POS_W-1:0] position;
		status_t status;
	} item_t;

	function automatic logic [CNT_W-1:0] lead_ones(input logic [WORD_W-1:0] v);
		logic going;
		logic [CNT_W-1:0] c;
		going = 1'b1;
		c = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (going && v[k]) begin
				c = c + CNT_W'(1);
			end else begin
				going = 1'b0;
			end
		end
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] trail_ones(input logic [WORD_W-1:0] v);
		logic going;
		logic [CNT_W-1:0] c;
		going = 1'b1;
		c = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (going && v[k]) begin
				c = c + CNT_W'(1);
			end else begin
				going = 1'b0;
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/cell_run_tracker_with_undo.sv -----
// A query reads the bitmap word of its cell, then further words to the left and then to the right
// while the run goes on across them, one word at a time: the single read port of the bitmap sets
// this. Destroy clears the cell in its word and pushes it onto the undo stack; rebuild pops the
// stack and sets that cell again. A request rejected at the front, or turned away on a full or
// empty stack, goes straight to its result. One item is carried out at a time; a two-entry request
// queue sits ahead of it. After reset the bitmap is filled with ones, during which no request is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cell_run_tracker_with_undo #(
	parameter int MAX_CELLS = crt_pkg::MAX_CELLS_DEF,
	localparam int NW = (MAX_CELLS + crt_pkg::WORD_W - 1) / crt_pkg::WORD_W,
	localparam int WAW = (NW > 1) ? $clog2(NW) : 1,
	localparam int CW = WAW + crt_pkg::BIT_W
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input crt_pkg::cmd_t cmd,
	output logic cmd_stall,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [crt_pkg::CFG_W-1:0] cfg_data,
	output logic res_valid,
	output crt_pkg::res_t res,
	input logic res_stall
);
	import crt_pkg::*;

	logic busy;
	logic fifo_full;
	logic push;
	item_t front_item;
	logic pop;
	item_t queued;
	logic queued_valid;
	logic [CW-1:0] last_cell;

	crt_front #(.MAX_CELLS(MAX_CELLS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_stall(cmd_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.busy(busy), .full(fifo_full), .push(push), .item(front_item),
		.last_cell(last_cell)
	);

	crt_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr(front_item), .full(fifo_full),
		.pop(pop), .rd(queued), .valid(queued_valid)
	);

	crt_back #(.MAX_CELLS(MAX_CELLS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(queued_valid), .item(queued), .pop(pop),
		.last_cell(last_cell), .busy(busy),
		.res(res), .res_valid(res_valid), .res_stall(res_stall)
	);

	`ASSERT_IMPLIES(a_err_no_run, res_valid && (res.status != ST_OK), res.run_length == '0, "failed request reports a run length")
	`ASSERT_IMPLIES(a_pop_has_item, pop, queued_valid, "pop from an empty request queue")
	`ASSERT_IMPLIES(a_init_queue_empty, busy, !queued_valid && !push, "request queued during bitmap fill")

endmodule

// ----- hw/rtl/crt_ram.sv -----
`timescale 1ns / 1ps
module crt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/crt_fifo.sv -----
`timescale 1ns / 1ps
module crt_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input crt_pkg::item_t wr,
	output logic full,
	input logic pop,
	output crt_pkg::item_t rd,
	output logic valid
);
	import crt_pkg::*;

	item_t slot_q [2];
	logic rptr_q;
	logic wptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= 1'b0;
			wptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr;
		end
	end

	assign rd = slot_q[rptr_q];
	assign valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);

endmodule

// ----- hw/rtl/crt_front.sv -----
`timescale 1ns / 1ps
module crt_front #(
	parameter int MAX_CELLS = crt_pkg::MAX_CELLS_DEF,
	localparam int NW = (MAX_CELLS + crt_pkg::WORD_W - 1) / crt_pkg::WORD_W,
	localparam int WAW = (NW > 1) ? $clog2(NW) : 1,
	localparam int CW = WAW + crt_pkg::BIT_W
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input crt_pkg::cmd_t cmd,
	output logic cmd_stall,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [crt_pkg::CFG_W-1:0] cfg_data,
	input logic busy,
	input logic full,
	output logic push,
	output crt_pkg::item_t item,
	output logic [CW-1:0] last_cell
);
	import crt_pkg::*;

	localparam int NCW = $clog2(MAX_CELLS + 1);
	localparam int CMPW = (NCW > CFG_W) ? NCW : CFG_W;

	logic [CFG_W-1:0] cells_q;
	logic [CMPW-1:0] cells_ext;
	logic [CMPW-1:0] n_c;
	logic in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= CELLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cells_q <= cfg_data;
		end
	end

	always_comb begin
		cells_ext = CMPW'(cells_q);
		if (cells_q == '0) begin
			n_c = CMPW'(1);
		end else if (cells_ext > CMPW'(MAX_CELLS)) begin
			n_c = CMPW'(MAX_CELLS);
		end else begin
			n_c = cells_ext;
		end
		in_range = (cmd.position != '0) && (CMPW'(cmd.position) <= n_c);
		item.position = cmd.position;
		case (cmd.command)
			CMD_QUERY: begin
				item.kind = in_range ? K_QUERY : K_REPORT;
				item.status = in_range ? ST_OK : ST_RANGE;
			end
			CMD_DESTROY: begin
				item.kind = in_range ? K_DESTROY : K_REPORT;
				item.status = in_range ? ST_OK : ST_RANGE;
			end
			CMD_REBUILD: begin
				item.kind = K_REBUILD;
				item.status = ST_OK;
			end
			default: begin
				item.kind = K_REPORT;
				item.status = ST_OK;
			end
		endcase
	end

	assign last_cell = CW'(n_c - CMPW'(1));
	assign cfg_ready = 1'b1;
	assign cmd_stall = busy || full;
	assign push = cmd_valid && !cmd_stall;

endmodule

// ----- hw/rtl/crt_back.sv -----
`timescale 1ns / 1ps
module crt_back #(
	parameter int MAX_CELLS = crt_pkg::MAX_CELLS_DEF,
	localparam int NW = (MAX_CELLS + crt_pkg::WORD_W - 1) / crt_pkg::WORD_W,
	localparam int WAW = (NW > 1) ? $clog2(NW) : 1,
	localparam int CW = WAW + crt_pkg::BIT_W
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input crt_pkg::item_t item,
	output logic pop,
	input logic [CW-1:0] last_cell,
	output logic busy,
	output crt_pkg::res_t res,
	output logic res_valid,
	input logic res_stall
);
	import crt_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int DW = $clog2(MAX_CELLS + 1);
	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

	state_t state_q, state_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [WAW-1:0] init_q, init_d;
	logic res_valid_q, res_valid_d;
	logic [WAW-1:0] word_q, word_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [WAW-1:0] lw_q, lw_d;
	logic [WAW-1:0] rw_q, rw_d;
	logic conr_q, conr_d;
	logic [RUN_W-1:0] run_q, run_d;
	status_t status_q, status_d;
	res_t res_q, res_d;

	logic bm_we;
	logic [WAW-1:0] bm_waddr, bm_raddr;
	logic [WORD_W-1:0] bm_wdata, bm_rdata;
	logic st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [CW-1:0] st_wdata, st_rdata;

	logic [CW-1:0] idx;
	logic [WAW-1:0] last_word;
	logic [BIT_W-1:0] last_bit;
	logic [WAW-1:0] mask_w;
	logic [WORD_W-1:0] rmask, masked, left_t, right_u;
	logic [CNT_W-1:0] lc, rc, full_lc, full_rc;

	crt_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	crt_ram #(.WIDTH(CW), .DEPTH(MAX_CELLS)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			depth_q <= '0;
			init_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			init_q <= init_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		bit_q <= bit_d;
		lw_q <= lw_d;
		rw_q <= rw_d;
		conr_q <= conr_d;
		run_q <= run_d;
		status_q <= status_d;
		res_q <= res_d;
	end

	always_comb begin
		idx = CW'(item.position - POS_W'(1));
		last_word = last_cell[CW-1:BIT_W];
		last_bit = last_cell[BIT_W-1:0];
		mask_w = (state_q == S_CENTER) ? word_q : rw_q;
		rmask = (mask_w == last_word) ? (ONES >> (BIT_W'(WORD_W - 1) - last_bit)) : ONES;
		masked = bm_rdata & rmask;
		left_t = bm_rdata << (CNT_W'(WORD_W) - {1'b0, bit_q});
		right_u = masked >> ({1'b0, bit_q} + CNT_W'(1));
		lc = lead_ones(left_t);
		rc = trail_ones(right_u);
		full_lc = lead_ones(bm_rdata);
		full_rc = trail_ones(masked);

		state_d = state_q;
		depth_d = depth_q;
		init_d = init_q;
		word_d = word_q;
		bit_d = bit_q;
		lw_d = lw_q;
		rw_d = rw_q;
		conr_d = conr_q;
		run_d = run_q;
		status_d = status_q;
		res_d = res_q;
		res_valid_d = res_valid_q && res_stall;
		pop = 1'b0;
		bm_we = 1'b0;
		bm_waddr = word_q;
		bm_wdata = ONES;
		bm_raddr = word_q;
		st_we = 1'b0;
		st_waddr = AW'(depth_q);
		st_wdata = {word_q, bit_q};
		st_raddr = AW'(depth_q - DW'(1));

		case (state_q)
			S_INIT: begin
				bm_we = 1'b1;
				bm_waddr = init_q;
				if (init_q == WAW'(NW - 1)) begin
					state_d = S_IDLE;
				end else begin
					init_d = init_q + WAW'(1);
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					pop = 1'b1;
					word_d = idx[CW-1:BIT_W];
					bit_d = idx[BIT_W-1:0];
					status_d = item.status;
					run_d = '0;
					bm_raddr = idx[CW-1:BIT_W];
					case (item.kind)
						K_QUERY: begin
							state_d = S_CENTER;
						end
						K_DESTROY: begin
							if (depth_q == DW'(MAX_CELLS)) begin
								status_d = ST_FULL;
								state_d = S_FINISH;
							end else begin
								state_d = S_DWR;
							end
						end
						K_REBUILD: begin
							if (depth_q == '0) begin
								status_d = ST_EMPTY;
								state_d = S_FINISH;
							end else begin
								depth_d = depth_q - DW'(1);
								state_d = S_RSTK;
							end
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_CENTER: begin
				lw_d = word_q - WAW'(1);
				rw_d = word_q + WAW'(1);
				conr_d = (rc == CNT_W'(WORD_W - 1) - {1'b0, bit_q}) && (word_q < last_word);
				if (!bm_rdata[bit_q]) begin
					state_d = S_FINISH;
				end else begin
					run_d = RUN_W'(1) + RUN_W'(lc) + RUN_W'(rc);
					if ((lc == {1'b0, bit_q}) && (word_q != '0)) begin
						bm_raddr = word_q - WAW'(1);
						state_d = S_LEFT;
					end else if (conr_d) begin
						bm_raddr = word_q + WAW'(1);
						state_d = S_RIGHT;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_LEFT: begin
				run_d = run_q + RUN_W'(full_lc);
				if ((full_lc == CNT_W'(WORD_W)) && (lw_q != '0)) begin
					bm_raddr = lw_q - WAW'(1);
					lw_d = lw_q - WAW'(1);
				end else if (conr_q) begin
					bm_raddr = rw_q;
					state_d = S_RIGHT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_RIGHT: begin
				run_d = run_q + RUN_W'(full_rc);
				if ((full_rc == CNT_W'(WORD_W)) && (rw_q < last_word)) begin
					bm_raddr = rw_q + WAW'(1);
					rw_d = rw_q + WAW'(1);
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DWR: begin
				bm_we = 1'b1;
				bm_wdata = bm_rdata & ~(WORD_W'(1) << bit_q);
				st_we = 1'b1;
				depth_d = depth_q + DW'(1);
				state_d = S_FINISH;
			end
			S_RSTK: begin
				word_d = st_rdata[CW-1:BIT_W];
				bit_d = st_rdata[BIT_W-1:0];
				bm_raddr = st_rdata[CW-1:BIT_W];
				state_d = S_RWR;
			end
			S_RWR: begin
				bm_we = 1'b1;
				bm_wdata = bm_rdata | (WORD_W'(1) << bit_q);
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					res_d.run_length = run_q;
					res_d.status = status_q;
					res_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q == S_INIT);
	assign res = res_q;
	assign res_valid = res_valid_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import crt_pkg::*;

	typedef struct {
		logic [1:0] command;
		logic [POS_W-1:0] position;
		int pause;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	cmd_t cmd = '0;
	logic cmd_stall;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic res_valid;
	res_t res;
	logic res_stall = 1'b0;

	pending_t request_queue[$];
	res_t expected_results[$];
	bit intact_map[1:MAX_CELLS_DEF];
	logic [9:0] broken_stack[$];
	logic [CFG_W-1:0] cells_reg;
	int errors = 0;
	int cycles = 0;
	int results_seen = 0;
	int queries_seen = 0;
	int send_gap = 0;
	int stall_gap = 0;
	bit quiet = 1'b0;
	bit driver_busy = 1'b0;
	bit config_busy = 1'b0;
	bit wait_drain = 1'b0;
	bit taken = 1'b0;

	cell_run_tracker_with_undo u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_stall(cmd_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.res_valid(res_valid), .res(res), .res_stall(res_stall)
	);

	always #6 clk = ~clk;

	function automatic res_t predict_run(input logic [1:0] op, input logic [POS_W-1:0] pos);
		res_t r;
		int n;
		int lo;
		int hi;
		n = cells_reg;
		r.run_length = '0;
		r.status = ST_OK;
		if (n == 0) n = 1;
		if (n > MAX_CELLS_DEF) n = MAX_CELLS_DEF;
		if (op == CMD_QUERY) begin
			if (pos < 1 || pos > n) begin
				r.status = ST_RANGE;
			end else if (intact_map[pos]) begin
				lo = pos;
				hi = pos;
				while (lo > 1 && intact_map[lo - 1]) lo--;
				while (hi < n && intact_map[hi + 1]) hi++;
				r.run_length = RUN_W'(hi - lo + 1);
			end
		end else if (op == CMD_DESTROY) begin
			if (pos < 1 || pos > n) begin
				r.status = ST_RANGE;
			end else if (broken_stack.size() >= MAX_CELLS_DEF) begin
				r.status = ST_FULL;
			end else begin
				broken_stack.push_back(10'(pos - 1));
				intact_map[pos] = 1'b0;
			end
		end else if (op == CMD_REBUILD) begin
			if (broken_stack.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				intact_map[int'(broken_stack.pop_back()) + 1] = 1'b1;
			end
		end
		return r;
	endfunction

	// The driver presents a new request at the falling edge once the previous one has been taken.
	always @(negedge clk) begin
		bit free;
		bit next_valid;
		pending_t p;
		if (arst_n && !config_busy) begin
			free = !cmd_valid || taken;
			next_valid = cmd_valid && !taken;
			taken = 1'b0;
			if (free) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (wait_drain) begin
					if (expected_results.size() == 0) wait_drain = 1'b0;
				end else if (request_queue.size() > 0) begin
					p = request_queue.pop_front();
					if (p.pause) wait_drain = 1'b1;
					cmd <= '{command: p.command, position: p.position};
					next_valid = 1'b1;
					if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 3);
				end
			end
			cmd_valid <= next_valid;
			driver_busy <= next_valid;
			if (stall_gap > 0) begin
				stall_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0) stall_gap = $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout at %0t", $time);
			$display("FAILURE");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) begin
			res_t e;
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, res);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (e.status == ST_OK && e.run_length != 0) queries_seen++;
				if (res.run_length !== e.run_length || res.status !== e.status) begin
					$display("%0t mismatch: expected %0d/%s actual %0d/%0d", $time,
						e.run_length, e.status.name(), res.run_length, res.status);
					errors++;
				end
			end
		end
		if (arst_n && cmd_valid && !cmd_stall) begin
			expected_results.push_back(predict_run(cmd.command, cmd.position));
			taken = 1'b1;
		end
	end

	task automatic push_request(input logic [1:0] op, input int pos, input int pause = 0);
		pending_t p;
		p.command = op;
		p.position = POS_W'(pos);
		p.pause = pause;
		request_queue.push_back(p);
	endtask

	task automatic settle;
		while (request_queue.size() > 0 || driver_busy || expected_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_cells(input int value);
		config_busy = 1'b1;
		@(negedge clk);
		cfg_data <= CFG_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cells_reg = CFG_W'(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		config_busy = 1'b0;
	endtask

	task automatic random_phase(input int count, input int hi);
		int k;
		int r;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 35) push_request(CMD_QUERY, $urandom_range(1, hi));
			else if (r < 65) push_request(CMD_DESTROY, $urandom_range(1, hi));
			else if (r < 88) push_request(CMD_REBUILD, $urandom_range(0, 2047));
			else if (r < 96) push_request(CMD_QUERY, $urandom_range(0, 2047));
			else push_request(2'd3, $urandom_range(0, 2047));
		end
	endtask

	initial begin
		int k;
		for (k = 1; k <= MAX_CELLS_DEF; k++) intact_map[k] = 1'b1;
		cells_reg = CELLS_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_request(CMD_QUERY, 1);
		push_request(CMD_QUERY, 1024);
		push_request(CMD_QUERY, 0);
		push_request(CMD_QUERY, 1025);
		push_request(CMD_QUERY, 2047);
		push_request(CMD_REBUILD, 0);
		push_request(CMD_DESTROY, 500);
		push_request(CMD_QUERY, 1);
		push_request(CMD_QUERY, 1024);
		push_request(CMD_QUERY, 500);
		push_request(CMD_DESTROY, 500);
		push_request(CMD_DESTROY, 1);
		push_request(CMD_DESTROY, 1024);
		push_request(CMD_DESTROY, 0);
		push_request(CMD_QUERY, 2);
		push_request(2'd3, 1365, 1);
		push_request(CMD_REBUILD, 682);
		push_request(CMD_REBUILD, 0);
		push_request(CMD_QUERY, 500);
		push_request(CMD_REBUILD, 0);
		push_request(CMD_QUERY, 500);
		random_phase(60, 64);
		settle();

		write_cells(1);
		push_request(CMD_QUERY, 1);
		push_request(CMD_QUERY, 2);
		push_request(CMD_DESTROY, 1);
		push_request(CMD_QUERY, 1);
		random_phase(30, 3);
		settle();

		write_cells(0);
		random_phase(20, 2);
		settle();

		write_cells(2047);
		random_phase(60, 1024);
		settle();

		write_cells(40);
		push_request(CMD_QUERY, 30);
		random_phase(120, 48);
		settle();

		write_cells(100);
		random_phase(80, 100);
		settle();
		quiet = 1'b1;
		write_cells(1024);
		random_phase(80, 1024);
		settle();

		$display("Ran %0d results, %0d with a non-zero run, over cell counts 0 to 2047.",
			results_seen, queries_seen);
		$display("Covered range, empty-stack and unknown-command cases under random stalls.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ----- cell_run_tracker_with_undo.f -----
+incdir+hw/rtl
hw/rtl/crt_pkg.sv
hw/rtl/crt_ram.sv
hw/rtl/crt_fifo.sv
hw/rtl/crt_front.sv
hw/rtl/crt_back.sv
hw/rtl/cell_run_tracker_with_undo.sv
tb/sv/tb_top.sv
